// File: design/bed_pkg.sv
// Shared types and fixed-point constants for the blink event detector.
// Used by blink_event_detector; depends on nothing.

package bed_pkg;

   // Q0.16 constants, rounded to nearest
   localparam logic [15:0] Q_MIN_BASE  = 16'd1311;   // 0.02
   localparam logic [15:0] Q_MAX_BASE  = 16'd26214;  // 0.40
   localparam logic [15:0] Q_MIN_CLOSE = 16'd983;    // 0.015
   localparam logic [15:0] Q_HYST      = 16'd524;    // 0.008
   localparam logic [15:0] Q_CLOSE_K   = 16'd39322;  // 0.60
   localparam logic [15:0] Q_OPEN_K    = 16'd51118;  // 0.78
   localparam logic [15:0] Q_KEEP      = 16'd64881;  // 0.99
   localparam logic [15:0] Q_TAKE     = 16'd655;    // 0.01
   localparam logic [31:0] Q_ROUND     = 32'd32768;

   localparam logic [3:0]  STREAK_MAX      = 4'd15;
   localparam logic [3:0]  CONFIRM_RESET   = 4'd2;
   localparam logic [15:0] MIN_BLINK_RESET = 16'd80;
   localparam logic [15:0] MAX_BLINK_RESET = 16'd800;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   typedef logic [3:0]  streak_type;
   typedef logic [15:0] ratio_type;

   typedef enum logic [1:0] {
      CSR_CONFIRM_FRAMES = 2'd0,
      CSR_MIN_BLINK_MS   = 2'd1,
      CSR_MAX_BLINK_MS   = 2'd2
   } csr_index_type;

   function automatic streak_type streak_inc(streak_type s);
      streak_inc = (s < STREAK_MAX) ? s + 4'd1 : STREAK_MAX;
   endfunction

endpackage

// File: design/blink_event_detector.sv
// Blink event detector: one dark-ratio word per frame in, one status word out.
// Depends on bed_pkg for constants and types.
//
// Usage:
//   req channel: one word per video frame. tuser is the measurement-valid flag,
//   tdata holds the dark-pixel ratio (Q0.16) and the frame timestamp in milliseconds.
//   rsp channel: one word for every request word, in order, carrying the
//   running blink total, the closure flag, a blink event flag and the blink
//   duration (zero when no event).
//   csr port: APB-style, confirm_frames at 0x0, min_blink_ms at 0x4,
//   max_blink_ms at 0x8. Write only while no word is in flight.
// Path: a word goes from the input register through the result register to rsp.
// Throughput: one word per cycle unless rsp stalls; the clock is set by the
// baseline threshold multiply followed by the compare chain in the decision stage.
// Reset: synchronous, clears the baseline, streaks, closure tracking and the
// blink counter, and loads the register defaults (2, 80, 800).
// Stall: while rsp_tready is low the result register holds; one more word
// may sit in the input register, after which req_tready drops.

module blink_event_detector #(
   parameter int TIME_WIDTH  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [bed_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] ratio, [47:16] time_ms
   input  logic        req_tuser,   // [0] measurement_valid
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [bed_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [15:0] blink_total, [16] eye_closed,
                                    // [17] blink_event, [33:18] blink_dur_ms,
                                    // [39:34] zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int TIME_IN_W = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
   localparam int CNT_EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   // configuration registers
   logic [3:0]  confirm_ff, confirm_in;
   logic [15:0] min_ms_ff, min_ms_in;
   logic [15:0] max_ms_ff, max_ms_in;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_meas_ff;
   bed_pkg::ratio_type    s1_ratio_ff;
   logic [TIME_WIDTH-1:0] s1_time_ff;

   // detector state
   bed_pkg::streak_type   closed_streak_ff, closed_streak_in;
   bed_pkg::streak_type   open_streak_ff, open_streak_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic                  closure_ff, closure_in;
   logic                  suppress_ff, suppress_in;
   logic                  ready_ff, ready_in;
   bed_pkg::ratio_type    baseline_ff, baseline_in;
   logic [TIME_WIDTH-1:0] close_start_ff, close_start_in;
   logic [TIME_WIDTH-1:0] reopen_start_ff, reopen_start_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [bed_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic advance;
   logic csr_write;
   bed_pkg::csr_index_type csr_index;

   // decision stage signals
   bed_pkg::ratio_type    base_cur;
   logic [31:0]           close_prod, open_prod, ema_sum;
   logic [15:0]           close_scaled, open_scaled, ema_raw;
   logic [16:0]           close_thr, open_thr;
   logic                  looks_shut, is_open;
   bed_pkg::streak_type   streak_next;
   logic [TIME_WIDTH-1:0] reopen_v, dur;
   logic                  out_closed, out_event;
   logic [15:0]           out_dur, out_total;
   logic [CNT_EXT_W-1:0]  count_ext;

   // ---------------- handshakes ----------------
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = bed_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      confirm_in = confirm_ff;
      min_ms_in  = min_ms_ff;
      max_ms_in  = max_ms_ff;
      csr_prdata = 32'd0;
      unique case (csr_index)
         bed_pkg::CSR_CONFIRM_FRAMES: begin
            csr_prdata = {28'd0, confirm_ff};
            if (csr_write) confirm_in = csr_pwdata[3:0];
         end
         bed_pkg::CSR_MIN_BLINK_MS: begin
            csr_prdata = {16'd0, min_ms_ff};
            if (csr_write) min_ms_in = csr_pwdata[15:0];
         end
         bed_pkg::CSR_MAX_BLINK_MS: begin
            csr_prdata = {16'd0, max_ms_ff};
            if (csr_write) max_ms_in = csr_pwdata[15:0];
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   // ---------------- thresholds and baseline average ----------------
   always_comb begin
      // seed from the first valid sample
      if (ready_ff) begin
         base_cur = baseline_ff;
      end else begin
         base_cur = (s1_ratio_ff > bed_pkg::Q_MIN_BASE) ? s1_ratio_ff : bed_pkg::Q_MIN_BASE;
      end
      close_prod   = 32'(base_cur) * 32'(bed_pkg::Q_CLOSE_K) + bed_pkg::Q_ROUND;
      open_prod    = 32'(base_cur) * 32'(bed_pkg::Q_OPEN_K) + bed_pkg::Q_ROUND;
      ema_sum      = 32'(base_cur) * 32'(bed_pkg::Q_KEEP)
                     + 32'(s1_ratio_ff) * 32'(bed_pkg::Q_TAKE) + bed_pkg::Q_ROUND;
      close_scaled = close_prod[31:16];
      open_scaled  = open_prod[31:16];
      ema_raw      = ema_sum[31:16];

      close_thr = (close_scaled < bed_pkg::Q_MIN_CLOSE) ? {1'b0, bed_pkg::Q_MIN_CLOSE}
                                                        : {1'b0, close_scaled};
      open_thr  = close_thr + {1'b0, bed_pkg::Q_HYST};
      if ({1'b0, open_scaled} > open_thr) open_thr = {1'b0, open_scaled};
      looks_shut = {1'b0, s1_ratio_ff} < close_thr;
      is_open    = {1'b0, s1_ratio_ff} > open_thr;
   end

   // ---------------- decision ----------------
   always_comb begin
      closed_streak_in = closed_streak_ff;
      open_streak_in   = open_streak_ff;
      counter_in       = counter_ff;
      closure_in       = closure_ff;
      suppress_in      = suppress_ff;
      ready_in         = ready_ff;
      baseline_in      = baseline_ff;
      close_start_in   = close_start_ff;
      reopen_start_in  = reopen_start_ff;
      out_closed       = closure_ff;
      out_event        = 1'b0;
      out_dur          = 16'd0;
      streak_next      = bed_pkg::streak_inc(open_streak_ff);
      reopen_v         = reopen_start_ff;
      dur              = '0;

      if (!s1_meas_ff) begin
         closed_streak_in = '0;
         open_streak_in   = '0;
         if (!suppress_ff) closure_in = 1'b0;
      end else begin
         ready_in    = 1'b1;
         baseline_in = base_cur;
         // track the open-eye level only while nothing is going on
         if (!closure_ff && !suppress_ff && !looks_shut) begin
            if (ema_raw < bed_pkg::Q_MIN_BASE) begin
               baseline_in = bed_pkg::Q_MIN_BASE;
            end else if (ema_raw > bed_pkg::Q_MAX_BASE) begin
               baseline_in = bed_pkg::Q_MAX_BASE;
            end else begin
               baseline_in = ema_raw;
            end
         end

         if (suppress_ff) begin
            if (is_open) begin
               open_streak_in = streak_next;
               if (streak_next >= confirm_ff) begin
                  suppress_in    = 1'b0;
                  open_streak_in = '0;
               end
            end else begin
               open_streak_in = '0;
            end
         end else if (!closure_ff) begin
            if (looks_shut) begin
               if (closed_streak_ff == '0) close_start_in = s1_time_ff;
               closed_streak_in = bed_pkg::streak_inc(closed_streak_ff);
               if (bed_pkg::streak_inc(closed_streak_ff) >= confirm_ff) begin
                  closure_in     = 1'b1;
                  open_streak_in = '0;
                  out_closed     = 1'b1;
               end
            end else begin
               closed_streak_in = '0;
            end
         end else if (is_open) begin
            if (open_streak_ff == '0) reopen_v = s1_time_ff;
            reopen_start_in = reopen_v;
            open_streak_in  = streak_next;
            if (streak_next >= confirm_ff) begin
               dur = reopen_v - close_start_ff;
               if (dur >= TIME_WIDTH'(min_ms_ff) && dur <= TIME_WIDTH'(max_ms_ff)) begin
                  if (counter_ff != {COUNT_WIDTH{1'b1}}) begin
                     counter_in = counter_ff + COUNT_WIDTH'(1);
                  end
                  out_event = 1'b1;
                  out_dur   = dur[15:0];
               end
               closure_in       = 1'b0;
               closed_streak_in = '0;
               open_streak_in   = '0;
               out_closed       = 1'b0;
            end
         end else begin
            open_streak_in = '0;
            dur = s1_time_ff - close_start_ff;
            // overlong closure: drop it and wait for the eye to reopen
            if (dur > TIME_WIDTH'(max_ms_ff)) begin
               closure_in       = 1'b0;
               closed_streak_in = '0;
               suppress_in      = 1'b1;
               out_closed       = 1'b0;
            end
         end
      end

      count_ext = CNT_EXT_W'(counter_in);
      out_total = (count_ext > CNT_EXT_W'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];
      rsp_data_in = {6'd0, out_dur, out_event, out_closed, out_total};
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_ff       <= bed_pkg::CONFIRM_RESET;
         min_ms_ff        <= bed_pkg::MIN_BLINK_RESET;
         max_ms_ff        <= bed_pkg::MAX_BLINK_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         closed_streak_ff <= '0;
         open_streak_ff   <= '0;
         counter_ff       <= '0;
         closure_ff       <= 1'b0;
         suppress_ff      <= 1'b0;
         ready_ff         <= 1'b0;
         baseline_ff      <= '0;
         close_start_ff   <= '0;
         reopen_start_ff  <= '0;
      end else begin
         confirm_ff   <= confirm_in;
         min_ms_ff    <= min_ms_in;
         max_ms_ff    <= max_ms_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            closed_streak_ff <= closed_streak_in;
            open_streak_ff   <= open_streak_in;
            counter_ff       <= counter_in;
            closure_ff       <= closure_in;
            suppress_ff      <= suppress_in;
            ready_ff         <= ready_in;
            baseline_ff      <= baseline_in;
            close_start_ff   <= close_start_in;
            reopen_start_ff  <= reopen_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_meas_ff  <= req_tuser;
         s1_ratio_ff <= req_tdata[15:0];
         s1_time_ff  <= TIME_WIDTH'(req_tdata[16 +: TIME_IN_W]);
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a completed blink always reports the eye as open again
   a_event_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[17] |-> !rsp_data_ff[16])
      else $error("blink event reported with eye closed");

   // duration is only nonzero on an event word
   a_dur_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[17] |-> rsp_data_ff[33:18] == 16'd0)
      else $error("blink duration without event");

   // suppression and an active closure exclude each other
   a_supp_excl: assert property (@(posedge clock) disable iff (reset)
      !(suppress_ff && closure_ff))
      else $error("closure active while suppressed");

   // the blink counter never goes backward
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> counter_ff >= $past(counter_ff))
      else $error("blink counter decreased");
`endif

endmodule
